FILE: hw/rtl/prs_pkg.sv
// Package for the pixel row sorter: sizes, codes and item types.
`default_nettype none
package prs_pkg;

   localparam int ROW_DEPTH  = 1024;
   localparam int IDX_W      = $clog2(ROW_DEPTH);
   localparam int OCC_W      = $clog2(ROW_DEPTH + 1);
   localparam int PIXEL_W    = 32;
   localparam int CHAN_CNT_W = 3;

   localparam logic [CHAN_CNT_W-1:0] THREE_CHANNELS = 3'd3;
   localparam logic [CHAN_CNT_W-1:0] FOUR_CHANNELS  = 3'd4;

   typedef enum logic [1:0] {
      ST_PIXEL = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] first_channel;
      logic [7:0] second_channel;
      logic [7:0] third_channel;
      logic [7:0] fourth_channel;
   } req_type;

   typedef struct packed {
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic [7:0] out_third;
      logic [7:0] out_fourth;
      logic [1:0] status;
   } rsp_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [OCC_W-1:0] occ;
   } ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/pixel_row_sorter.sv
// Pixel row sorter: handshake control, occupancy and the chain of sorting cells.
//
// Push items store one pixel in a row of ROW_DEPTH cells kept in ascending
// lexicographic order (first channel most significant), smallest at cell 0.
// A pop item returns the smallest pixel, or status empty; a push into a full
// row returns status full and stores nothing. A successful push returns no item.
// Channels: req_ (valid/stall, push or pop), rsp_ (valid/stall, result),
// csr_ (valid/ready, channel count 3 or 4, always ready).
// Throughput: one item per cycle while req_stall is low; every cell compares
// and shifts in parallel, so a push inserts and a pop shifts the whole row.
// Result path: a result appears on rsp_ in the cycle after its item is accepted,
// from a single output register.
// When the receiver stalls with a result held, req_stall rises until the
// result is taken; the held result does not change.
// Reset empties the row (occupancy zero) and sets three-channel mode; the
// cell contents are not cleared and no clearing pass is needed.
`default_nettype none
module pixel_row_sorter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire prs_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output prs_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [prs_pkg::CHAN_CNT_W-1:0]    csr_data
);

   logic [prs_pkg::CHAN_CNT_W-1:0] chan_cnt_ff;
   logic [prs_pkg::OCC_W-1:0]      occ_ff;
   logic [prs_pkg::OCC_W-1:0]      occ_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   prs_pkg::rsp_type               rsp_data_ff;
   prs_pkg::rsp_type               rsp_data_in;

   logic                           accept;
   logic                           four_mode;
   logic                           full;
   logic                           empty;
   logic                           is_pop;
   logic                           result_now;
   logic [prs_pkg::PIXEL_W-1:0]    key;
   logic [prs_pkg::PIXEL_W-1:0]    head;
   prs_pkg::ctl_type               ctl;

   logic [prs_pkg::PIXEL_W-1:0]    entries [prs_pkg::ROW_DEPTH];
   logic                           ins     [prs_pkg::ROW_DEPTH];

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign four_mode = chan_cnt_ff == prs_pkg::FOUR_CHANNELS;
   assign full      = occ_ff == prs_pkg::OCC_W'(prs_pkg::ROW_DEPTH);
   assign empty     = occ_ff == '0;
   assign is_pop    = req_data.mode == prs_pkg::MODE_POP;

   assign key = {req_data.first_channel, req_data.second_channel, req_data.third_channel,
                 four_mode ? req_data.fourth_channel : 8'd0};

   assign ctl.push = accept && !is_pop && !full;
   assign ctl.pop  = accept && is_pop && !empty;
   assign ctl.occ  = occ_ff;

   // Pushes that drop and all pops give a result
   assign result_now = accept && (is_pop || full);
   assign head       = entries[0];

   always_comb begin
      occ_in = occ_ff;
      if (ctl.push) begin
         occ_in = occ_ff + 1'b1;
      end else if (ctl.pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (is_pop && !empty) begin
         rsp_data_in.out_first  = head[31:24];
         rsp_data_in.out_second = head[23:16];
         rsp_data_in.out_third  = head[15:8];
         rsp_data_in.out_fourth = four_mode ? head[7:0] : 8'd0;
         rsp_data_in.status     = prs_pkg::ST_PIXEL;
      end else if (is_pop) begin
         rsp_data_in.status = prs_pkg::ST_EMPTY;
      end else begin
         rsp_data_in.status = prs_pkg::ST_FULL;
      end
   end

   assign rsp_valid_in = result_now || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff  <= prs_pkg::THREE_CHANNELS;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            chan_cnt_ff <= csr_data;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_now) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < prs_pkg::ROW_DEPTH; i++) begin : g_cell
      logic [prs_pkg::PIXEL_W-1:0] left_entry;
      logic                        left_ins;
      logic [prs_pkg::PIXEL_W-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_ins   = 1'b0;
      end else begin : g_body
         assign left_entry = entries[i-1];
         assign left_ins   = ins[i-1];
      end

      if (i == prs_pkg::ROW_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_next
         assign right_entry = entries[i+1];
      end

      prs_cell u_cell (
         .clock       (clock),
         .idx         (prs_pkg::IDX_W'(i)),
         .ctl         (ctl),
         .key         (key),
         .left_entry  (left_entry),
         .left_ins    (left_ins),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .ins         (ins[i])
      );
   end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_cell.sv
// One slot of the sorting chain: holds a pixel and inserts, shifts or keeps it each cycle.
`default_nettype none
module prs_cell (
   input  wire logic                          clock,
   input  wire logic [prs_pkg::IDX_W-1:0]     idx,
   input  wire prs_pkg::ctl_type              ctl,
   input  wire logic [prs_pkg::PIXEL_W-1:0]   key,
   input  wire logic [prs_pkg::PIXEL_W-1:0]   left_entry,
   input  wire logic                          left_ins,
   input  wire logic [prs_pkg::PIXEL_W-1:0]   right_entry,
   output logic      [prs_pkg::PIXEL_W-1:0]   entry,
   output logic                               ins
);

   logic [prs_pkg::PIXEL_W-1:0] entry_ff;
   logic [prs_pkg::PIXEL_W-1:0] entry_in;
   logic [prs_pkg::OCC_W-1:0]   pos;
   logic                        occupied;

   assign pos      = prs_pkg::OCC_W'(idx);
   assign occupied = pos < ctl.occ;
   // Slot opens where the stored entry is larger, or at the first free slot
   assign ins      = (occupied && (entry_ff > key)) || (pos == ctl.occ);
   assign entry    = entry_ff;

   always_comb begin
      if (ctl.push && ins) begin
         entry_in = left_ins ? left_entry : key;
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire
